FILE: rtl/mks_pkg.sv
// Package for the matrix keypad scanner: geometry, event codes, key map,
// state and response structures. No dependencies.
package mks_pkg;

   // keypad geometry
   localparam int NUM_ROWS = 5;
   localparam int NUM_COLS = 4;
   localparam int IDX_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

   // fixed widths of the request and response fields
   localparam int MODE_W  = 2;
   localparam int COL_W   = 4;
   localparam int DRIVE_W = 5;
   localparam int CODE_W  = 7;
   localparam int COUNT_W = 8;

   // key map geometry
   localparam int MAP_ROWS = 5;
   localparam int MAP_COLS = 4;

   // event codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_SCAN     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEBOUNCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EDGE     = 2'd2;

   // ASCII key map, table row 0 first
   localparam logic [CODE_W-1:0] KEYMAP [MAP_ROWS][MAP_COLS] = '{
      '{7'h46, 7'h66, 7'h23, 7'h2A},
      '{7'h31, 7'h32, 7'h33, 7'h55},
      '{7'h34, 7'h35, 7'h36, 7'h44},
      '{7'h37, 7'h38, 7'h39, 7'h45},
      '{7'h4C, 7'h30, 7'h52, 7'h41}
   };

   // scanner state
   typedef struct packed {
      logic [IDX_W-1:0]   row_index;
      logic [DRIVE_W-1:0] row_drive;
      logic               scan_running;
      logic               debounce_phase;
      logic [COUNT_W-1:0] press_count;
   } state_type;

   // one response
   typedef struct packed {
      logic [DRIVE_W-1:0] row_drive;
      logic               scanning;
      logic               key_valid;
      logic [CODE_W-1:0]  key_code;
      logic [COUNT_W-1:0] key_count;
   } rsp_type;

endpackage

FILE: rtl/mks_if.sv
// Request and response channel interfaces of the keypad scanner.
// Depends on mks_pkg for field widths.
interface mks_req_if;
   logic                         valid;
   logic                         ready;
   logic [mks_pkg::MODE_W-1:0]   mode;
   logic [mks_pkg::COL_W-1:0]    column_lines;

   modport source (output valid, output mode, output column_lines, input ready);
   modport sink   (input valid, input mode, input column_lines, output ready);
endinterface

interface mks_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mks_pkg::DRIVE_W-1:0]  row_drive;
   logic                         scanning;
   logic                         key_valid;
   logic [mks_pkg::CODE_W-1:0]   key_code;
   logic [mks_pkg::COUNT_W-1:0]  key_count;

   modport source (output valid, output row_drive, output scanning, output key_valid,
                   output key_code, output key_count, input ready);
   modport sink   (input valid, input row_drive, input scanning, input key_valid,
                   input key_code, input key_count, output ready);
endinterface

FILE: rtl/matrix_keypad_scanner.sv
// Matrix keypad scanner: input register, event step logic, response register.
// An accepted request waits in the input register until the response register is free.
// Throughput: one request per cycle unless rsp_chan.ready stalls the response register.
// Reset (synchronous, active high) clears both stage valids and state, but sets scanning on.
// Depends on mks_pkg, mks_if and mks_step.
module matrix_keypad_scanner (
   input logic        clock,
   input logic        reset,
   mks_req_if.sink    req_chan,
   mks_rsp_if.source  rsp_chan
);

   logic                         in_valid_ff;
   logic                         in_valid_in;
   logic [mks_pkg::MODE_W-1:0]   in_mode_ff;
   logic [mks_pkg::COL_W-1:0]    in_cols_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   mks_pkg::rsp_type             out_ff;
   mks_pkg::state_type           state_ff;
   mks_pkg::state_type           state_in;
   mks_pkg::rsp_type             step_rsp;
   logic                         advance;
   logic                         req_take;

   // move the held request on when the response register is free
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   mks_step u_step (
      .state        (state_ff),
      .mode         (in_mode_ff),
      .column_lines (in_cols_ff),
      .state_next   (state_in),
      .rsp          (step_rsp)
   );

   // stage valids
   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{row_index: '0, row_drive: '0, scan_running: 1'b1,
                           debounce_phase: 1'b0, press_count: '0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   // capture request payload and response
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_chan.mode;
         in_cols_ff <= req_chan.column_lines;
      end
      if (advance) out_ff <= step_rsp;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.row_drive = out_ff.row_drive;
   assign rsp_chan.scanning  = out_ff.scanning;
   assign rsp_chan.key_valid = out_ff.key_valid;
   assign rsp_chan.key_code  = out_ff.key_code;
   assign rsp_chan.key_count = out_ff.key_count;

   // at most one row driven at any time
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(state_ff.row_drive))
      else $error("row drive not one-hot");

   // state moves only when a request passes the step logic
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a request");

   // a decoded key always leaves the scan frozen
   a_key_frozen: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.key_valid) |-> !out_ff.scanning)
      else $error("key reported while scanning");

   // an empty response register never blocks the input side
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_chan.ready)
      else $error("input stalled with free response register");

   // a press bumps the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (advance && step_rsp.key_valid) |=>
         (state_ff.press_count == $past(state_ff.press_count) + 8'd1))
      else $error("press count did not advance");

endmodule

FILE: rtl/mks_step.sv
// Next-state and response logic for one keypad event.
// Depends on mks_pkg.
module mks_step (
   input  mks_pkg::state_type              state,
   input  logic [mks_pkg::MODE_W-1:0]      mode,
   input  logic [mks_pkg::COL_W-1:0]       column_lines,
   output mks_pkg::state_type              state_next,
   output mks_pkg::rsp_type                rsp
);

   logic [mks_pkg::COL_W-1:0]  cols;
   logic [mks_pkg::DRIVE_W-1:0] drive_next;
   logic [mks_pkg::IDX_W-1:0]   idx_next;
   int                          col_pos;
   int                          row_pos;
   int                          trow;
   logic                        key_valid;
   logic [mks_pkg::CODE_W-1:0]  key_code;

   // drop column bits beyond the keypad width
   always_comb begin
      for (int i = 0; i < mks_pkg::COL_W; i++) begin
         cols[i] = column_lines[i] && (i < mks_pkg::NUM_COLS);
      end
   end

   // highest set column and driven row
   always_comb begin
      col_pos = -1;
      for (int i = 0; i < mks_pkg::COL_W; i++) begin
         if (cols[i]) col_pos = i;
      end
      row_pos = -1;
      for (int i = 0; i < mks_pkg::DRIVE_W; i++) begin
         if (state.row_drive[i]) row_pos = i;
      end
      trow = (mks_pkg::NUM_ROWS - 1) - row_pos;
   end

   // advance the row index modulo the row count and drive it one-hot
   always_comb begin
      if (int'(state.row_index) == mks_pkg::NUM_ROWS - 1) begin
         idx_next = '0;
      end else begin
         idx_next = state.row_index + 1'b1;
      end
      for (int i = 0; i < mks_pkg::DRIVE_W; i++) begin
         drive_next[i] = (i < mks_pkg::NUM_ROWS) && (int'(idx_next) == i);
      end
   end

   // apply the event when it arrives in the matching mode
   always_comb begin
      state_next = state;
      key_valid  = 1'b0;
      key_code   = '0;
      case (mode)
         mks_pkg::MODE_SCAN: begin
            if (state.scan_running) begin
               state_next.row_index = idx_next;
               state_next.row_drive = drive_next;
            end
         end
         mks_pkg::MODE_DEBOUNCE: begin
            if (!state.scan_running) begin
               if (state.debounce_phase) begin
                  if (cols == '0) state_next.scan_running = 1'b1;
                  state_next.debounce_phase = 1'b0;
               end else begin
                  state_next.debounce_phase = 1'b1;
               end
            end
         end
         mks_pkg::MODE_EDGE: begin
            if (state.scan_running) begin
               state_next.scan_running = 1'b0;
               if (col_pos >= 0 && row_pos >= 0) begin
                  key_valid = 1'b1;
                  if (trow >= 0 && trow < mks_pkg::MAP_ROWS && col_pos < mks_pkg::MAP_COLS) begin
                     key_code = mks_pkg::KEYMAP[($clog2(mks_pkg::MAP_ROWS))'(trow)]
                                               [($clog2(mks_pkg::MAP_COLS))'(col_pos)];
                  end
                  state_next.press_count = state.press_count + 1'b1;
               end
            end
         end
         default: begin
            state_next = state;
         end
      endcase
   end

   // report the state after this event
   always_comb begin
      rsp.row_drive = state_next.row_drive;
      rsp.scanning  = state_next.scan_running;
      rsp.key_valid = key_valid;
      rsp.key_code  = key_code;
      rsp.key_count = state_next.press_count;
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for matrix_keypad_scanner: random and directed scan, debounce and
// column-edge requests, with responses checked against an in-bench keypad predictor.
// Depends on mks_pkg, mks_if and the scanner RTL.
module testbench;

   localparam logic [mks_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;

   localparam int RANDOM_REQUESTS = 1830;
   localparam int HOLD_AT         = 600;
   localparam int DRAIN_AT        = 1200;
   localparam int LONG_HOLD       = 300;
   localparam int QUIET_TAIL      = 150;
   localparam int TAIL_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int REPORT_LIMIT    = 10;

   // key legends, table row 0 first
   localparam logic [mks_pkg::CODE_W-1:0] KEY_CHARS [5][4] = '{
      '{7'h46, 7'h66, 7'h23, 7'h2A},   // F f # *
      '{7'h31, 7'h32, 7'h33, 7'h55},   // 1 2 3 U
      '{7'h34, 7'h35, 7'h36, 7'h44},   // 4 5 6 D
      '{7'h37, 7'h38, 7'h39, 7'h45},   // 7 8 9 E
      '{7'h4C, 7'h30, 7'h52, 7'h41}    // L 0 R A
   };

   typedef enum logic [1:0] {
      PLAN_REQUEST,
      PLAN_DRAIN,
      PLAN_HOLD
   } plan_kind_type;

   typedef struct {
      plan_kind_type               kind;
      logic [mks_pkg::MODE_W-1:0]  mode;
      logic [mks_pkg::COL_W-1:0]   cols;
   } planned_type;

   logic clock;
   logic reset;

   mks_req_if req_bus ();
   mks_rsp_if rsp_bus ();

   matrix_keypad_scanner uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // request plan and expected responses
   planned_type      request_plan [$];
   mks_pkg::rsp_type expected_reports [$];

   // predicted scanner state
   logic [2:0]                  row_at;
   logic [mks_pkg::DRIVE_W-1:0] row_lines;
   logic                        scan_on;
   logic                        settle_phase;
   logic [mks_pkg::COUNT_W-1:0] presses;

   int  requests_sent;
   int  reports_seen;
   int  keys_decoded;
   int  count_wraps;
   int  mismatches;
   int  planned_count;
   int  stall_cycles;
   int  hold_requests;
   int  hold_served;
   int  hold_left;
   int  send_gap;
   int  recv_gap;
   int  send_idle_pct;
   int  recv_idle_pct;
   logic draining;
   logic late_phase;
   logic stim_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int highest_bit(logic [7:0] v);
      int pos;
      pos = -1;
      for (int i = 0; i < 8; i++) begin
         if (v[i]) pos = i;
      end
      return pos;
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(2))
         0: return 0;
         1: return 8;
         default: return 30;
      endcase
   endfunction

   // advance the predicted scanner by one request and return its response
   function automatic mks_pkg::rsp_type keypad_step(logic [mks_pkg::MODE_W-1:0] mode,
                                                    logic [mks_pkg::COL_W-1:0] cols);
      mks_pkg::rsp_type rsp;
      int               col_hi;
      int               row_hi;
      rsp = '0;
      if (mode == mks_pkg::MODE_SCAN && scan_on) begin
         row_at    = (row_at == mks_pkg::NUM_ROWS - 1) ? 3'd0 : row_at + 3'd1;
         row_lines = 5'b00001 << row_at;
      end else if (mode == mks_pkg::MODE_DEBOUNCE && !scan_on) begin
         // resume only on the second tick, and only with every column released
         if (settle_phase) begin
            if (cols == '0) scan_on = 1'b1;
            settle_phase = 1'b0;
         end else begin
            settle_phase = 1'b1;
         end
      end else if (mode == mks_pkg::MODE_EDGE && scan_on) begin
         // freeze always; decode only with a driven row and a set column
         scan_on = 1'b0;
         col_hi  = highest_bit({4'b0, cols});
         row_hi  = highest_bit({3'b0, row_lines});
         if (col_hi >= 0 && row_hi >= 0) begin
            // with a 5 by 4 geometry the table index never leaves the key map
            rsp.key_valid = 1'b1;
            rsp.key_code  = KEY_CHARS[3'(mks_pkg::NUM_ROWS - 1 - row_hi)][2'(col_hi)];
            presses       = presses + 8'd1;
            keys_decoded++;
            if (presses == '0) count_wraps++;
         end
      end
      rsp.row_drive = row_lines;
      rsp.scanning  = scan_on;
      rsp.key_count = presses;
      return rsp;
   endfunction

   task automatic plan_request(logic [mks_pkg::MODE_W-1:0] mode,
                               logic [mks_pkg::COL_W-1:0] cols);
      planned_type p;
      p.kind = PLAN_REQUEST;
      p.mode = mode;
      p.cols = cols;
      request_plan.push_back(p);
      planned_count++;
      // slot in the pressure points once their turn comes
      if (planned_count == HOLD_AT || planned_count == DRAIN_AT) begin
         p.kind = (planned_count == HOLD_AT) ? PLAN_HOLD : PLAN_DRAIN;
         request_plan.push_back(p);
      end
   endtask

   task automatic report_mismatch(string field, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch on report %0d, %s: expected %0d, got %0d",
                  reports_seen, field, want, got);
   endtask

   // drive requests from the plan
   always @(posedge clock) begin : drive_requests
      planned_type                head;
      logic                       offer;
      logic [mks_pkg::MODE_W-1:0] nxt_mode;
      logic [mks_pkg::COL_W-1:0]  nxt_cols;
      offer    = req_bus.valid;
      nxt_mode = req_bus.mode;
      nxt_cols = req_bus.column_lines;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_reports.push_back(keypad_step(req_bus.mode, req_bus.column_lines));
            requests_sent++;
            offer = 1'b0;
            if (requests_sent % 64 == 0) send_idle_pct = pick_idle_pct();
         end
         late_phase = (request_plan.size() < QUIET_TAIL);
         if (draining && expected_reports.size() == 0) draining = 1'b0;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!draining && request_plan.size() > 0) begin
               if (!late_phase && $urandom_range(99) < send_idle_pct) begin
                  send_gap = $urandom_range(11, 0);
               end else begin
                  // take markers until a request turns up
                  while (!offer && !draining && request_plan.size() > 0) begin
                     head = request_plan.pop_front();
                     case (head.kind)
                        PLAN_DRAIN: draining = 1'b1;
                        PLAN_HOLD:  hold_requests++;
                        default: begin
                           offer    = 1'b1;
                           nxt_mode = head.mode;
                           nxt_cols = head.cols;
                        end
                     endcase
                  end
               end
            end
         end
         stim_done = !offer && !draining && request_plan.size() == 0;
      end
      req_bus.valid        <= offer;
      req_bus.mode         <= nxt_mode;
      req_bus.column_lines <= nxt_cols;
   end

   // take responses, check them and pace the ready line
   always @(posedge clock) begin : collect_reports
      mks_pkg::rsp_type want;
      mks_pkg::rsp_type got;
      logic             take;
      take = rsp_bus.ready;
      if (reset) begin
         take = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.row_drive = rsp_bus.row_drive;
            got.scanning  = rsp_bus.scanning;
            got.key_valid = rsp_bus.key_valid;
            got.key_code  = rsp_bus.key_code;
            got.key_count = rsp_bus.key_count;
            reports_seen++;
            if (reports_seen % 64 == 0) recv_idle_pct = pick_idle_pct();
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("report %0d arrived with no request pending", reports_seen);
            end else begin
               want = expected_reports.pop_front();
               if (got.row_drive !== want.row_drive)
                  report_mismatch("row_drive", want.row_drive, got.row_drive);
               if (got.scanning !== want.scanning)
                  report_mismatch("scanning", want.scanning, got.scanning);
               if (got.key_valid !== want.key_valid)
                  report_mismatch("key_valid", want.key_valid, got.key_valid);
               if (got.key_code !== want.key_code)
                  report_mismatch("key_code", want.key_code, got.key_code);
               if (got.key_count !== want.key_count)
                  report_mismatch("key_count", want.key_count, got.key_count);
            end
         end
         if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            take = 1'b0;
         end else if (!late_phase && $urandom_range(99) < recv_idle_pct) begin
            recv_gap = $urandom_range(11, 0);
            take     = 1'b0;
         end else begin
            take = 1'b1;
         end
      end
      rsp_bus.ready <= take;
   end

   // count cycles in which neither side moves
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
   end

   initial begin : watchdog
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no request or report moved for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
   end

   initial begin : run_test
      int n;
      int kind_roll;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.mode         = mks_pkg::MODE_SCAN;
      req_bus.column_lines = '0;
      rsp_bus.ready        = 1'b0;
      row_at        = '0;
      row_lines     = '0;
      scan_on       = 1'b1;
      settle_phase  = 1'b0;
      presses       = '0;
      requests_sent = 0;
      reports_seen  = 0;
      keys_decoded  = 0;
      count_wraps   = 0;
      mismatches    = 0;
      planned_count = 0;
      stall_cycles  = 0;
      hold_requests = 0;
      hold_served   = 0;
      hold_left     = 0;
      send_gap      = 0;
      recv_gap      = 0;
      send_idle_pct = pick_idle_pct();
      recv_idle_pct = pick_idle_pct();
      draining      = 1'b0;
      late_phase    = 1'b0;
      stim_done     = 1'b0;

      // edge before any row is driven: freeze without a key
      plan_request(mks_pkg::MODE_EDGE, 4'b1111);
      // wrong-mode requests while frozen, and the reserved mode
      plan_request(mks_pkg::MODE_SCAN, 4'b0000);
      plan_request(mks_pkg::MODE_EDGE, 4'b0001);
      plan_request(MODE_RESERVED, 4'b1010);
      // columns still held on the second tick: stay frozen
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0101);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0010);
      // released on the first tick only counts on the second
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
      // debounce tick while scanning is ignored
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b1111);
      plan_request(MODE_RESERVED, 4'b0101);
      // edge with no column set: freeze without a key
      plan_request(mks_pkg::MODE_SCAN, 4'b0000);
      plan_request(mks_pkg::MODE_EDGE, 4'b0000);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
      // wrap the row index back to row 0, press the top column
      repeat (4) plan_request(mks_pkg::MODE_SCAN, 4'b1111);
      plan_request(mks_pkg::MODE_EDGE, 4'b1000);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
      // last row, lowest column
      repeat (4) plan_request(mks_pkg::MODE_SCAN, 4'b0000);
      plan_request(mks_pkg::MODE_EDGE, 4'b0001);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
      plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);

      // random presses with bounce, mixed with noise
      while (planned_count < RANDOM_REQUESTS) begin
         kind_roll = $urandom_range(99);
         if (kind_roll < 15) begin
            plan_request(2'($urandom_range(3)), 4'($urandom_range(15)));
         end else begin
            n = $urandom_range(3, 0);
            repeat (n) plan_request(mks_pkg::MODE_SCAN, 4'($urandom_range(15)));
            plan_request(mks_pkg::MODE_EDGE,
                         ($urandom_range(9) == 0) ? 4'b0 : 4'($urandom_range(15)));
            if (kind_roll < 35) begin
               n = $urandom_range(4, 1);
               repeat (n) plan_request(mks_pkg::MODE_DEBOUNCE, 4'($urandom_range(15, 1)));
            end
            plan_request(mks_pkg::MODE_DEBOUNCE, 4'($urandom_range(15)));
            plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
            plan_request(mks_pkg::MODE_DEBOUNCE, 4'b0000);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // wait for the plan to run out and every report to arrive
      while (!(stim_done && expected_reports.size() == 0)) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         mismatches += expected_reports.size();
         $display("%0d expected reports never arrived", expected_reports.size());
      end

      $display("summary: %0d requests, %0d reports, %0d keys decoded, count wrapped %0d times",
               requests_sent, reports_seen, keys_decoded, count_wraps);
      $display("summary: %0d long receiver holds, %0d mismatches", hold_served, mismatches);
      if (mismatches == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule

FILE: matrix_keypad_scanner.f
rtl/mks_pkg.sv
rtl/mks_if.sv
rtl/mks_step.sv
rtl/matrix_keypad_scanner.sv
verif/testbench.sv
